[hw/rtl/llbrc_pkg.sv]
// ----------------------------------------------------------------------------
// LED latch and banked RAM controller package
// Field widths, bus codes and the item and result records shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package llbrc_pkg;

  localparam int MODE_W    = 3;
  localparam int BYTE_W    = 8;
  localparam int BANK_W    = 2;
  localparam int SEL_W     = 3;
  localparam int CMD_W     = 4;
  localparam int DELAY_W   = 12;
  localparam int LATCH_COUNT = 5;
  localparam int PATTERN_W = LATCH_COUNT * BYTE_W;

  // Bus operation codes.
  localparam logic [MODE_W-1:0] MODE_RAM_READ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RAM_WRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PORT1     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PORT2     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TICK      = 3'd4;

  localparam logic [SEL_W-1:0]   SEL_NONE    = 3'd0;
  localparam logic [SEL_W-1:0]   SEL_SOUND   = 3'd6;
  localparam int                 STROBE_BIT  = 4;
  localparam int                 EA_BIT      = 2;
  localparam logic [DELAY_W-1:0] DELAY_RESET = 12'd39;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] offset;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]    read_data;
    logic [PATTERN_W-1:0] led_pattern;
    logic                 led_enable;
    logic                 sound_reset;
    logic                 external_access;
    logic [CMD_W-1:0]     sound_command;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/llbrc_ifs.sv]
// ----------------------------------------------------------------------------
// LED latch and banked RAM controller channels
// Valid/ready interfaces for bus items, results and the delay register write.
// ----------------------------------------------------------------------------
`default_nettype none

interface llbrc_item_if;
  import llbrc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] offset;
  logic [BYTE_W-1:0] data;
  modport source (output valid, mode, offset, data, input ready);
  modport sink   (input valid, mode, offset, data, output ready);
endinterface

interface llbrc_result_if;
  import llbrc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_W-1:0]    read_data;
  logic [PATTERN_W-1:0] led_pattern;
  logic                 led_enable;
  logic                 sound_reset;
  logic                 external_access;
  logic [CMD_W-1:0]     sound_command;
  modport source (output valid, read_data, led_pattern, led_enable, sound_reset,
                  external_access, sound_command, input ready);
  modport sink   (input valid, read_data, led_pattern, led_enable, sound_reset,
                  external_access, sound_command, output ready);
endinterface

interface llbrc_cfg_if;
  import llbrc_pkg::*;
  logic               valid;
  logic               ready;
  logic [DELAY_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/llbrc_ram.sv]
// ----------------------------------------------------------------------------
// Work RAM
// Single-port byte memory with a registered read that holds until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module llbrc_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/llbrc_core.sv]
// ----------------------------------------------------------------------------
// Latch and timer core
// Applies one bus item per advancing cycle to the latch, strobe, timer, sound and external access state.
// ----------------------------------------------------------------------------
`default_nettype none

module llbrc_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire llbrc_pkg::item_t               item,
  input  wire logic [7:0]                     rd_byte,
  input  wire logic                           cfg_we,
  input  wire logic [llbrc_pkg::DELAY_W-1:0]  cfg_data,
  output llbrc_pkg::result_t                  res_next
);
  import llbrc_pkg::*;

  logic [DELAY_W-1:0] led_off_delay;
  logic [SEL_W-1:0]   latch_select, latch_select_next;
  logic               strobe_level, strobe_level_next;
  logic               leds_lit, leds_lit_next;
  logic [BYTE_W-1:0]  column_latches [LATCH_COUNT];
  logic [BYTE_W-1:0]  column_latches_next [LATCH_COUNT];
  logic [BYTE_W-1:0]  column_outputs [LATCH_COUNT];
  logic [BYTE_W-1:0]  column_outputs_next [LATCH_COUNT];
  logic [DELAY_W-1:0] off_countdown, off_countdown_next;
  logic               off_running, off_running_next;
  logic [CMD_W-1:0]   sound_cmd_reg, sound_cmd_reg_next;
  logic               sound_reset_reg, sound_reset_reg_next;
  logic               ea_reg, ea_reg_next;

  always_comb begin
    latch_select_next    = latch_select;
    strobe_level_next    = strobe_level;
    leds_lit_next        = leds_lit;
    column_latches_next  = column_latches;
    column_outputs_next  = column_outputs;
    off_countdown_next   = off_countdown;
    off_running_next     = off_running;
    sound_cmd_reg_next   = sound_cmd_reg;
    sound_reset_reg_next = sound_reset_reg;
    ea_reg_next          = ea_reg;
    case (item.mode)
      MODE_RAM_READ: begin
        // Select 1..5 maps onto latch 5-select; the byte is stored inverted.
        for (int k = 0; k < LATCH_COUNT; k++) begin
          if (latch_select == SEL_W'(LATCH_COUNT - k)) begin
            column_latches_next[k] = ~rd_byte;
          end
        end
        if (latch_select == SEL_SOUND) begin
          sound_reset_reg_next = ~rd_byte[0];
        end
      end
      MODE_PORT1: begin
        ea_reg_next = item.data[EA_BIT];
      end
      MODE_PORT2: begin
        latch_select_next = item.data[7:5];
        if (latch_select_next == SEL_NONE && !off_running) begin
          off_countdown_next = led_off_delay;
          off_running_next   = 1'b1;
        end
        if (!strobe_level && item.data[STROBE_BIT]) begin
          column_outputs_next = column_latches;
          leds_lit_next       = 1'b1;
          off_running_next    = 1'b0;
        end
        strobe_level_next  = item.data[STROBE_BIT];
        sound_cmd_reg_next = item.data[7:4];
      end
      MODE_TICK: begin
        if (off_running) begin
          if (off_countdown <= DELAY_W'(1)) begin
            off_countdown_next = '0;
            off_running_next   = 1'b0;
            leds_lit_next      = 1'b0;
          end else begin
            off_countdown_next = off_countdown - DELAY_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res_next.read_data = (item.mode == MODE_RAM_READ) ? rd_byte : '0;
    for (int k = 0; k < LATCH_COUNT; k++) begin
      res_next.led_pattern[k*BYTE_W +: BYTE_W] = column_outputs_next[k];
    end
    res_next.led_enable      = leds_lit_next;
    res_next.sound_reset     = sound_reset_reg_next;
    res_next.external_access = ea_reg_next;
    res_next.sound_command   = sound_cmd_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_off_delay <= DELAY_RESET;
    end else if (cfg_we) begin
      led_off_delay <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latch_select    <= '0;
      strobe_level    <= 1'b0;
      leds_lit        <= 1'b0;
      column_latches  <= '{default: '0};
      column_outputs  <= '{default: '0};
      off_countdown   <= '0;
      off_running     <= 1'b0;
      sound_cmd_reg   <= '0;
      sound_reset_reg <= 1'b1;
      ea_reg          <= 1'b0;
    end else if (adv) begin
      latch_select    <= latch_select_next;
      strobe_level    <= strobe_level_next;
      leds_lit        <= leds_lit_next;
      column_latches  <= column_latches_next;
      column_outputs  <= column_outputs_next;
      off_countdown   <= off_countdown_next;
      off_running     <= off_running_next;
      sound_cmd_reg   <= sound_cmd_reg_next;
      sound_reset_reg <= sound_reset_reg_next;
      ea_reg          <= ea_reg_next;
    end
  end

  // A tick on the last count blanks the LEDs and stops the timer.
  a_idle_timer_blanks: assert property (@(posedge clk) disable iff (rst)
    adv && item.mode == MODE_TICK && off_running && off_countdown <= DELAY_W'(1)
    |=> !leds_lit && !off_running)
    else $error("timer expiry did not blank the LEDs");

endmodule

`default_nettype wire

[hw/rtl/led_latch_banked_ram_controller.sv]
// ----------------------------------------------------------------------------
// LED latch and banked RAM controller
// Banked work RAM with LED column latches, strobe, blanking timer and sound
// processor control lines.
//
//   Channel  Direction  Payload
//   item     in         mode, offset, data
//   result   out        read_data, led_pattern, led_enable, sound_reset,
//                       external_access, sound_command
//   cfg      in         data (led_off_delay)
//
// One item is accepted per cycle while item ready is high; it passes through the
// registered RAM read in the middle stage and then the result register before
// its result is valid.
// A stalled result holds the middle stage, and ready falls only when both the
// middle stage and the result register are full.
// Reset returns all control state to its defaults at once; the work RAM is not cleared.
// The delay register is always ready and is written on every valid transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module led_latch_banked_ram_controller #(
  parameter int RAM_BYTES = 1024
) (
  input wire logic  clk,
  input wire logic  rst,
  llbrc_item_if.sink     item,
  llbrc_result_if.source result,
  llbrc_cfg_if.sink      cfg
);
  import llbrc_pkg::*;

  localparam int AW = $clog2(RAM_BYTES);
  localparam int FW = 12;
  localparam logic [FW-1:0] SPAN1 = FW'(RAM_BYTES);
  localparam logic [FW-1:0] SPAN2 = FW'(2 * RAM_BYTES);

  logic              item_acc;
  logic              s1_valid;
  item_t             s1_item;
  logic              s1_adv;
  logic              out_free;
  logic              out_valid;
  result_t           out_res;
  result_t           res_next;
  logic [BANK_W-1:0] ram_bank;
  logic [FW-1:0]     full_addr, addr_a, addr_b;
  logic [AW-1:0]     ram_addr;
  logic [7:0]        rd_byte;

  assign out_free   = !out_valid || result.ready;
  assign s1_adv     = s1_valid && out_free;
  assign item.ready = !s1_valid || out_free;
  assign item_acc   = item.valid && item.ready;
  assign cfg.ready  = 1'b1;

  // The raw address is below four banks, so two conditional subtracts wrap it.
  assign full_addr = {{(FW - BANK_W - BYTE_W){1'b0}}, ram_bank, item.offset};
  assign addr_a    = (full_addr >= SPAN2) ? full_addr - SPAN2 : full_addr;
  assign addr_b    = (addr_a >= SPAN1) ? addr_a - SPAN1 : addr_a;
  assign ram_addr  = addr_b[AW-1:0];

  // The bank only steers addressing, so it is taken at transfer time.
  always_ff @(posedge clk) begin
    if (rst) begin
      ram_bank <= '0;
    end else if (item_acc && item.mode == MODE_PORT1) begin
      ram_bank <= item.data[BANK_W-1:0];
    end
  end

  llbrc_ram #(
    .DEPTH (RAM_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (item_acc && item.mode == MODE_RAM_WRITE),
    .re    (item_acc && item.mode == MODE_RAM_READ),
    .addr  (ram_addr),
    .wdata (item.data),
    .rdata (rd_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_item <= '{mode: item.mode, offset: item.offset, data: item.data};
    end
  end

  llbrc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .adv      (s1_adv),
    .item     (s1_item),
    .rd_byte  (rd_byte),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .res_next (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.read_data       = out_res.read_data;
  assign result.led_pattern     = out_res.led_pattern;
  assign result.led_enable      = out_res.led_enable;
  assign result.sound_reset     = out_res.sound_reset;
  assign result.external_access = out_res.external_access;
  assign result.sound_command   = out_res.sound_command;

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |-> !item.ready)
    else $error("item taken while the middle stage was blocked");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    item_acc |=> s1_valid)
    else $error("accepted item did not reach the middle stage");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("advanced item did not reach the result register");

endmodule

`default_nettype wire
